// ===== hdl/qprm_pkg.sv =====
// Shared types, constants and the round-and-saturate function for the
// quaternion product to rotation matrix core. No dependencies.
`default_nettype none

package qprm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int WORD_W    = 16;
  localparam int PROD_W    = 2 * WORD_W;
  // Accumulator: a sum of four full products, or twice a diagonal sum, plus the
  // rounding half. It also has to hold the constant one at 2*FRAC_BITS fraction bits.
  localparam int ACC_W     = (2 * FRAC_BITS + 2 > PROD_W + 2) ? 2 * FRAC_BITS + 2 : PROD_W + 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Packed so that w sits in the lowest bits.
  typedef struct packed {
    word_t z;
    word_t y;
    word_t x;
    word_t w;
  } quat_t;

  typedef struct packed {
    logic  clip;
    word_t val;
  } rs_t;

  localparam acc_t ONE_ACC  = ACC_W'(1) << (2 * FRAC_BITS);
  localparam acc_t HALF_ACC = ACC_W'(1) << (FRAC_BITS - 1);
  localparam acc_t SAT_MIN  = ACC_W'(-32768);
  localparam acc_t SAT_MAX  = ACC_W'(32767);

  function automatic acc_t sx(input prod_t p);
    sx = ACC_W'(p);
  endfunction

  // Round to nearest with ties toward plus infinity, then clamp to a word.
  function automatic rs_t round_sat(input acc_t v);
    acc_t r;
    rs_t  res;
    r = (v + HALF_ACC) >>> FRAC_BITS;
    if (r < SAT_MIN) begin
      res.clip = 1'b1;
      res.val  = word_t'(SAT_MIN);
    end else if (r > SAT_MAX) begin
      res.clip = 1'b1;
      res.val  = word_t'(SAT_MAX);
    end else begin
      res.clip = 1'b0;
      res.val  = word_t'(r);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/qprm_hamilton.sv =====
// Three-stage Hamilton product A*B: sixteen products, four sums, then
// round and saturate each component. Depends on qprm_pkg.
`default_nettype none

module qprm_hamilton (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire qprm_pkg::quat_t a,
  input  wire qprm_pkg::quat_t b,
  output logic               q_valid,
  output qprm_pkg::quat_t    q,
  output logic               q_clip
);
  import qprm_pkg::*;

  word_t av [4];
  word_t bv [4];
  prod_t prod_r [16];
  prod_t prod_nxt [16];
  acc_t  sum_r [4];
  acc_t  sum_nxt [4];
  rs_t   rs [4];
  quat_t q_r;
  logic  clip_r;
  logic [2:0] valid_r;

  assign av[0] = a.w;
  assign av[1] = a.x;
  assign av[2] = a.y;
  assign av[3] = a.z;
  assign bv[0] = b.w;
  assign bv[1] = b.x;
  assign bv[2] = b.y;
  assign bv[3] = b.z;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_nxt[i*4+j] = av[i] * bv[j];
      end
    end
  end

  // Index i*4+j is a_i * b_j with components ordered w, x, y, z.
  always_comb begin
    sum_nxt[0] = sx(prod_r[0])  - sx(prod_r[5])  - sx(prod_r[10]) - sx(prod_r[15]);
    sum_nxt[1] = sx(prod_r[1])  + sx(prod_r[4])  + sx(prod_r[11]) - sx(prod_r[14]);
    sum_nxt[2] = sx(prod_r[2])  - sx(prod_r[7])  + sx(prod_r[8])  + sx(prod_r[13]);
    sum_nxt[3] = sx(prod_r[3])  + sx(prod_r[6])  - sx(prod_r[9])  + sx(prod_r[12]);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rs[k] = round_sat(sum_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      sum_r  <= sum_nxt;
      q_r.w  <= rs[0].val;
      q_r.x  <= rs[1].val;
      q_r.y  <= rs[2].val;
      q_r.z  <= rs[3].val;
      clip_r <= rs[0].clip | rs[1].clip | rs[2].clip | rs[3].clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[1:0], in_valid};
    end
  end

  assign q_valid = valid_r[2];
  assign q       = q_r;
  assign q_clip  = clip_r;

endmodule

`default_nettype wire

// ===== hdl/qprm_rotmat.sv =====
// Three-stage conversion of a quaternion into nine rotation matrix words:
// ten products, nine sums, then round and saturate. Depends on qprm_pkg.
`default_nettype none

module qprm_rotmat (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          q_valid,
  input  wire qprm_pkg::quat_t q,
  input  wire logic          q_clip,
  output logic               m_valid,
  output qprm_pkg::word_t    m [9],
  output logic               m_clip
);
  import qprm_pkg::*;

  // Products in order: ww, xx, yy, zz, xy, wz, xz, wy, yz, wx.
  prod_t prod_r [10];
  prod_t prod_nxt [10];
  acc_t  sum_r [9];
  acc_t  sum_nxt [9];
  rs_t   rs [9];
  word_t m_r [9];
  logic  clip1_r, clip2_r, m_clip_r;
  logic  any_clip;
  logic [2:0] valid_r;

  always_comb begin
    prod_nxt[0] = q.w * q.w;
    prod_nxt[1] = q.x * q.x;
    prod_nxt[2] = q.y * q.y;
    prod_nxt[3] = q.z * q.z;
    prod_nxt[4] = q.x * q.y;
    prod_nxt[5] = q.w * q.z;
    prod_nxt[6] = q.x * q.z;
    prod_nxt[7] = q.w * q.y;
    prod_nxt[8] = q.y * q.z;
    prod_nxt[9] = q.w * q.x;
  end

  always_comb begin
    sum_nxt[0] = ((sx(prod_r[0]) + sx(prod_r[1])) <<< 1) - ONE_ACC;
    sum_nxt[1] = (sx(prod_r[4]) - sx(prod_r[5])) <<< 1;
    sum_nxt[2] = (sx(prod_r[6]) + sx(prod_r[7])) <<< 1;
    sum_nxt[3] = (sx(prod_r[4]) + sx(prod_r[5])) <<< 1;
    sum_nxt[4] = ((sx(prod_r[0]) + sx(prod_r[2])) <<< 1) - ONE_ACC;
    sum_nxt[5] = (sx(prod_r[8]) - sx(prod_r[9])) <<< 1;
    sum_nxt[6] = (sx(prod_r[6]) - sx(prod_r[7])) <<< 1;
    sum_nxt[7] = (sx(prod_r[8]) + sx(prod_r[9])) <<< 1;
    sum_nxt[8] = ((sx(prod_r[0]) + sx(prod_r[3])) <<< 1) - ONE_ACC;
  end

  always_comb begin
    any_clip = clip2_r;
    for (int k = 0; k < 9; k++) begin
      rs[k]    = round_sat(sum_r[k]);
      any_clip = any_clip | rs[k].clip;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod_nxt;
      clip1_r  <= q_clip;
      sum_r    <= sum_nxt;
      clip2_r  <= clip1_r;
      for (int k = 0; k < 9; k++) begin
        m_r[k] <= rs[k].val;
      end
      m_clip_r <= any_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[1:0], q_valid};
    end
  end

  assign m_valid = valid_r[2];
  assign m       = m_r;
  assign m_clip  = m_clip_r;

endmodule

`default_nettype wire

// ===== hdl/quaternion_product_to_rotation_matrix_core.sv =====
// Top level: stream ports around the Hamilton product and matrix stages.
// Depends on qprm_pkg, qprm_hamilton and qprm_rotmat.
//
// One request carries two quaternions in signed Q2.14 and yields one request
// with the nine rotation matrix words of their product, each rounded to nearest
// and saturated, plus a flag in out_tuser that is set when any rounding step
// clipped. The block takes a new request every cycle and delivers one result
// per cycle unless out_tready is low with a result waiting. It has six
// register stages: products, sums and rounding for the quaternion, then the
// same three steps for the matrix, the last register being the output. All
// six stages advance together and hold while out_tready is low with a result
// waiting, so in_tready follows out_tready in that case. The block keeps no
// state between requests.
`default_nettype none

module quaternion_product_to_rotation_matrix_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z from bit 0 up, 16 bits each
  input  wire logic [127:0]  in_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22
  // from bit 0 up, 16 bits each
  output logic [143:0]       out_tdata,
  // clipped
  output logic               out_tuser
);
  import qprm_pkg::*;

  logic  en;
  logic  q_valid, q_clip;
  quat_t q;
  word_t m [9];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  qprm_hamilton u_ham (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .a        (quat_t'(in_tdata[63:0])),
    .b        (quat_t'(in_tdata[127:64])),
    .q_valid  (q_valid),
    .q        (q),
    .q_clip   (q_clip)
  );

  qprm_rotmat u_rot (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .q_valid (q_valid),
    .q       (q),
    .q_clip  (q_clip),
    .m_valid (out_tvalid),
    .m       (m),
    .m_clip  (out_tuser)
  );

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      out_tdata[k*WORD_W +: WORD_W] = m[k];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qprm_checker.sv =====
// Port-level checks for the quaternion product to rotation matrix core,
// bound to the top level. Uses only the top level's ports.
`default_nettype none

module qprm_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [143:0] out_tdata,
  input wire logic         out_tuser
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result present right after reset");

  // Input is taken exactly when the output stage can move.
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not track the output stage");

  // A diagonal element is at least -1 in Q2.14, even for clipped products.
  a_diag_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:14] != 2'b10 && out_tdata[79:78] != 2'b10
                    && out_tdata[143:142] != 2'b10))
    else $error("diagonal element below -1");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind quaternion_product_to_rotation_matrix_core qprm_checker u_qprm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
